[hw/rtl/ccut_pkg.sv]
`timescale 1ns / 1ps
package ccut_pkg;
	localparam int MAX_DIM_DEF     = 8;
	localparam int MAX_SAMPLES_DEF = 65536;

	localparam int A_W     = 16;
	localparam int CFG_W   = 4;
	localparam int CNT_W   = 17;
	localparam int SA_W    = 32;
	localparam int PROD_W  = 2 * A_W;
	localparam int SP_W    = 48;
	localparam int HALF_W  = SP_W / 2;
	localparam int NUM_W   = 68;
	localparam int DEN_W   = 34;
	localparam int DCNT_W  = $clog2(NUM_W);
	localparam int COV_W   = 34;
	localparam int OIDX_W  = 3;

	localparam logic [CFG_W-1:0] ACTIVE_DIM_RST = CFG_W'(8);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC_RD,
		ST_MAC_WR,
		ST_END,
		ST_EDEN,
		ST_E_RD,
		ST_E_MUL,
		ST_E_ADD,
		ST_E_SUB,
		ST_E_ABS,
		ST_E_DIV,
		ST_E_OUT,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic accept;
		logic cfg_wr;
		logic mac_rd;
		logic mac_wr;
		logic end_elem;
		logic emit_init;
		logic e_rd;
		logic e_mul;
		logic e_add;
		logic e_sub;
		logic e_abs;
		logic div_step;
		logic out_load;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic acc;
		logic mac_last;
		logic elem_last;
		logic fin;
		logic div_done;
		logic out_free;
		logic ent_last;
	} sts_t;
endpackage

[hw/rtl/ccut_ctrl.sv]
`timescale 1ns / 1ps
module ccut_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            cfg_valid,
	output logic            in_stall,
	output logic            cfg_ready,
	input  ccut_pkg::sts_t  sts,
	output ccut_pkg::cmd_t  cmd
);
	import ccut_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cfg_ready = 1'b0;
		in_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				cfg_ready = 1'b1;
				in_stall  = cfg_valid;
				if (cfg_valid) begin
					cmd.cfg_wr = 1'b1;
				end else if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.acc ? ST_MAC_RD : ST_END;
				end
			end
			ST_MAC_RD: begin
				cmd.mac_rd = 1'b1;
				state_d    = ST_MAC_WR;
			end
			ST_MAC_WR: begin
				cmd.mac_wr = 1'b1;
				state_d    = sts.mac_last ? ST_END : ST_MAC_RD;
			end
			ST_END: begin
				cmd.end_elem = 1'b1;
				state_d      = (sts.elem_last && sts.fin) ? ST_EDEN : ST_IDLE;
			end
			ST_EDEN: begin
				cmd.emit_init = 1'b1;
				state_d       = ST_E_RD;
			end
			ST_E_RD: begin
				cmd.e_rd = 1'b1;
				state_d  = ST_E_MUL;
			end
			ST_E_MUL: begin
				cmd.e_mul = 1'b1;
				state_d   = ST_E_ADD;
			end
			ST_E_ADD: begin
				cmd.e_add = 1'b1;
				state_d   = ST_E_SUB;
			end
			ST_E_SUB: begin
				cmd.e_sub = 1'b1;
				state_d   = ST_E_ABS;
			end
			ST_E_ABS: begin
				cmd.e_abs = 1'b1;
				state_d   = ST_E_DIV;
			end
			ST_E_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = ST_E_OUT;
			end
			ST_E_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = sts.ent_last ? ST_CLEAR : ST_E_RD;
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

[hw/rtl/ccut_dp.sv]
`timescale 1ns / 1ps
module ccut_dp #(
	parameter int MAX_DIM     = ccut_pkg::MAX_DIM_DEF,
	parameter int MAX_SAMPLES = ccut_pkg::MAX_SAMPLES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ccut_pkg::cmd_t                       cmd,
	output ccut_pkg::sts_t                       sts,
	input  logic [ccut_pkg::CFG_W-1:0]           active_dim,
	input  logic signed [ccut_pkg::A_W-1:0]      a_value,
	input  logic signed [ccut_pkg::A_W-1:0]      b_value,
	input  logic                                 final_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [ccut_pkg::COV_W-1:0]    cov_value,
	output logic [ccut_pkg::OIDX_W-1:0]          row_index,
	output logic [ccut_pkg::OIDX_W-1:0]          col_index,
	output logic                                 last_entry
);
	import ccut_pkg::*;

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CFG_W-1:0] dim_q, dim;
	logic [IDX_W-1:0] dim_m1, pos_q, pos_eff, epos_q, mi_q, ei_q, ej_q, sidx, bidx;
	logic [CNT_W-1:0] cnt_q;
	logic             acc, fin_q;

	logic signed [A_W-1:0]  cur_a_q [MAX_DIM];
	logic signed [A_W-1:0]  b_q;
	logic signed [SA_W-1:0] sum_a_q [MAX_DIM];
	logic signed [SA_W-1:0] sum_b_q [MAX_DIM];
	logic signed [SA_W-1:0] sa_rd, sb_rd, sa_q, sb_q;

	logic [SP_W-1:0]          sp_mem [DEPTH];
	logic [DEPTH-1:0]         sp_vld_q;
	logic [AW-1:0]            raddr, waddr_q;
	logic [SP_W-1:0]          rd_q, sab;
	logic                     rd_vld_q;
	logic signed [PROD_W-1:0] prod_q;

	logic [CNT_W+HALF_W-1:0]          p_lo_q;
	logic signed [CNT_W+HALF_W:0]     p_hi_q;
	logic signed [2*SA_W-1:0]         ab_q;
	logic [NUM_W-1:0]                 nsab_q, num_q, quot_q, cov_full;
	logic                             neg_q;
	logic [DEN_W-1:0]                 den_q, rem_q;
	logic [DEN_W:0]                   rem_sh;
	logic                             ge;
	logic [DCNT_W-1:0]                dcnt_q;
	logic                             out_valid_q;

	assign dim = (dim_q == '0) ? CFG_W'(1) :
		((dim_q > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : dim_q);
	assign dim_m1  = IDX_W'(dim - CFG_W'(1));
	assign pos_eff = (CFG_W'(pos_q) >= dim) ? '0 : pos_q;
	assign acc     = cnt_q < CNT_W'(MAX_SAMPLES);

	// one read port each on the sum registers
	assign sidx  = cmd.e_rd ? ei_q : pos_eff;
	assign bidx  = cmd.e_rd ? ej_q : pos_eff;
	assign sa_rd = sum_a_q[sidx];
	assign sb_rd = sum_b_q[bidx];

	assign raddr = cmd.e_rd ? AW'(int'(ei_q) * MAX_DIM + int'(ej_q))
	                        : AW'(int'(mi_q) * MAX_DIM + int'(epos_q));

	assign sab    = rd_vld_q ? rd_q : '0;
	assign rem_sh = {rem_q, quot_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	// floor: negative quotient rounds away from zero when remainder nonzero
	assign cov_full = (den_q == '0) ? '0 :
		(neg_q ? (~quot_q + NUM_W'(rem_q == '0)) : quot_q);

	assign sts.acc       = acc;
	assign sts.mac_last  = (mi_q == epos_q);
	assign sts.elem_last = (epos_q == dim_m1);
	assign sts.fin       = fin_q;
	assign sts.div_done  = (dcnt_q == DCNT_W'(NUM_W - 1));
	assign sts.out_free  = !out_valid_q || !out_stall;
	assign sts.ent_last  = (ei_q == dim_m1) && (ej_q == dim_m1);

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q       <= ACTIVE_DIM_RST;
			pos_q       <= '0;
			cnt_q       <= '0;
			mi_q        <= '0;
			ei_q        <= '0;
			ej_q        <= '0;
			dcnt_q      <= '0;
			sp_vld_q    <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < MAX_DIM; k++) begin
				sum_a_q[k] <= '0;
				sum_b_q[k] <= '0;
			end
		end else begin
			if (cmd.cfg_wr) dim_q <= active_dim;
			if (cmd.cfg_wr || cmd.clear) begin
				pos_q    <= '0;
				cnt_q    <= '0;
				sp_vld_q <= '0;
				for (int k = 0; k < MAX_DIM; k++) begin
					sum_a_q[k] <= '0;
					sum_b_q[k] <= '0;
				end
			end else begin
				if (cmd.accept && acc) begin
					sum_a_q[pos_eff] <= sa_rd + SA_W'(a_value);
					sum_b_q[pos_eff] <= sb_rd + SA_W'(b_value);
				end
				if (cmd.mac_wr) sp_vld_q[waddr_q] <= 1'b1;
				if (cmd.end_elem) begin
					if (epos_q == dim_m1) begin
						pos_q <= '0;
						if (acc) cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						pos_q <= epos_q + IDX_W'(1);
					end
				end
			end
			if (cmd.accept) mi_q <= '0;
			if (cmd.mac_wr) mi_q <= mi_q + IDX_W'(1);
			if (cmd.emit_init) begin
				ei_q <= '0;
				ej_q <= '0;
			end
			if (cmd.e_abs) dcnt_q <= '0;
			if (cmd.div_step) dcnt_q <= dcnt_q + DCNT_W'(1);
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				if (ej_q == dim_m1) begin
					ei_q <= ei_q + IDX_W'(1);
					ej_q <= ei_q + IDX_W'(1);
				end else begin
					ej_q <= ej_q + IDX_W'(1);
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q     <= sp_mem[raddr];
		rd_vld_q <= sp_vld_q[raddr];
		if (cmd.mac_wr) sp_mem[waddr_q] <= sab + SP_W'(prod_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_a_q[pos_eff] <= a_value;
			b_q              <= b_value;
			fin_q            <= final_sample;
			epos_q           <= pos_eff;
		end
		if (cmd.mac_rd) begin
			prod_q  <= cur_a_q[mi_q] * b_q;
			waddr_q <= raddr;
		end
		if (cmd.emit_init) den_q <= DEN_W'(cnt_q * cnt_q);
		if (cmd.e_rd) begin
			sa_q <= sa_rd;
			sb_q <= sb_rd;
		end
		if (cmd.e_mul) begin
			p_lo_q <= cnt_q * sab[HALF_W-1:0];
			p_hi_q <= $signed({1'b0, cnt_q}) * $signed(sab[SP_W-1:HALF_W]);
			ab_q   <= sa_q * sb_q;
		end
		if (cmd.e_add) nsab_q <= (NUM_W'(p_hi_q) << HALF_W) + NUM_W'(p_lo_q);
		if (cmd.e_sub) num_q <= nsab_q - NUM_W'(ab_q);
		if (cmd.e_abs) begin
			neg_q  <= num_q[NUM_W-1];
			quot_q <= num_q[NUM_W-1] ? (~num_q + NUM_W'(1)) : num_q;
			rem_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quot_q <= {quot_q[NUM_W-2:0], ge};
		end
		if (cmd.out_load) begin
			cov_value  <= cov_full[COV_W-1:0];
			row_index  <= OIDX_W'(ei_q);
			col_index  <= OIDX_W'(ej_q);
			last_entry <= (ei_q == dim_m1) && (ej_q == dim_m1);
		end
	end
endmodule

[hw/rtl/cross_covariance_upper_triangle_top.sv]
`timescale 1ns / 1ps
// Upper-triangle cross-covariance engine.
// Input channel (in_valid / in_stall): one request per feature element,
// carrying a_value, b_value (signed Q7.8) and final_sample. Elements of a
// sample arrive in order 0 .. active_dim-1; final_sample counts only on
// the last element. Element e forms e+1 products with one shared 16x16
// multiply-accumulate against the product memory, each product a read
// then a write back. After a final sample the block emits d*(d+1)/2
// results (cov_value Q.16, row_index, col_index, last_entry) in row-major
// order, d being active_dim clamped to 1 .. MAX_DIM.
// Each entry runs five setup steps (read, multiply, add, subtract, abs), a
// 68-step restoring divide forming floor((n*Sab - Sa*Sb) / n^2), and a load.
// Input is stalled during emission.
// Output (out_valid / out_stall): a result register holds the request while
// out_stall is high; the divider of the next entry runs meanwhile.
// Config (cfg_valid / cfg_ready): writes active_dim, taken only when idle;
// a write also clears all sums and the sample count.
// Reset: active_dim = 8, all sums and counts zero, no result pending.
// Samples past MAX_SAMPLES are not accumulated.
module cross_covariance_upper_triangle_top #(
	parameter int MAX_DIM     = ccut_pkg::MAX_DIM_DEF,
	parameter int MAX_SAMPLES = ccut_pkg::MAX_SAMPLES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [ccut_pkg::A_W-1:0]      a_value,
	input  logic signed [ccut_pkg::A_W-1:0]      b_value,
	input  logic                                 final_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [ccut_pkg::COV_W-1:0]    cov_value,
	output logic [ccut_pkg::OIDX_W-1:0]          row_index,
	output logic [ccut_pkg::OIDX_W-1:0]          col_index,
	output logic                                 last_entry,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ccut_pkg::CFG_W-1:0]           active_dim
);
	import ccut_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: element MAC loop, then per-entry numerator / divide / output
	ccut_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cfg_valid (cfg_valid),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// sums, product memory, multipliers, divider and result register
	ccut_dp #(
		.MAX_DIM     (MAX_DIM),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.active_dim   (active_dim),
		.a_value      (a_value),
		.b_value      (b_value),
		.final_sample (final_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cov_value    (cov_value),
		.row_index    (row_index),
		.col_index    (col_index),
		.last_entry   (last_entry)
	);
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import ccut_pkg::*;

	// Bounds of the run
	localparam int DIM_CAP     = MAX_DIM_DEF;
	localparam int COUNT_CAP   = MAX_SAMPLES_DEF;
	localparam int SETTLE_CYC  = 200;    // quiet cycles before a register write
	localparam int HOLD_CYC    = 3000;   // one long receiver hold-off
	localparam int WATCHDOG    = 40000;  // cycles with no request accepted
	localparam int MAX_REPORTS = 10;

	// One pending request: either a feature element or a register write
	typedef struct {
		bit                    is_cfg;
		logic [CFG_W-1:0]      dim;
		logic signed [A_W-1:0] a;
		logic signed [A_W-1:0] b;
		bit                    fin;
		bit                    no_gap;
	} request_t;

	typedef struct {
		logic [COV_W-1:0]  cov;
		logic [OIDX_W-1:0] row;
		logic [OIDX_W-1:0] col;
		logic              last;
	} cov_entry_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [A_W-1:0] a_value;
	logic signed [A_W-1:0] b_value;
	logic final_sample;
	logic out_valid;
	logic out_stall;
	logic signed [COV_W-1:0] cov_value;
	logic [OIDX_W-1:0] row_index;
	logic [OIDX_W-1:0] col_index;
	logic last_entry;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_dim;

	request_t   pending_q[$];
	cov_entry_t cov_expect_q[$];
	int         mismatches = 0;
	int         entries_seen = 0;

	// Shadow of the block state
	logic [CFG_W-1:0] dim_reg;
	int               elem_pos;
	int               n_samples;
	longint           last_a[DIM_CAP];
	longint           sum_a_sh[DIM_CAP];
	longint           sum_b_sh[DIM_CAP];
	longint           sum_ab_sh[DIM_CAP][DIM_CAP];

	cross_covariance_upper_triangle_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.a_value      (a_value),
		.b_value      (b_value),
		.final_sample (final_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cov_value    (cov_value),
		.row_index    (row_index),
		.col_index    (col_index),
		.last_entry   (last_entry),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.active_dim   (cfg_dim)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int used_dim();
		int d;
		d = dim_reg;
		if (d == 0) d = 1;
		if (d > DIM_CAP) d = DIM_CAP;
		return d;
	endfunction

	// Clear sums; done on reset, on every register write and after each emission
	task automatic clear_sums();
		elem_pos = 0;
		n_samples = 0;
		for (int i = 0; i < DIM_CAP; i++) begin
			last_a[i] = 0;
			sum_a_sh[i] = 0;
			sum_b_sh[i] = 0;
			for (int j = 0; j < DIM_CAP; j++) sum_ab_sh[i][j] = 0;
		end
	endtask

	// Accumulate one accepted element; on the closing element of a final
	// sample, queue every upper-triangle covariance entry in row-major order.
	task automatic accumulate_element(input logic signed [A_W-1:0] a,
			input logic signed [A_W-1:0] b, input bit fin);
		int d;
		int p;
		bit room;
		logic signed [127:0] num;
		logic signed [127:0] den;
		logic signed [127:0] quo;
		logic signed [127:0] wn;
		cov_entry_t e;
		d = used_dim();
		p = elem_pos;
		room = n_samples < COUNT_CAP;
		if (p >= d) p = 0;
		last_a[p] = a;
		if (room) begin
			sum_a_sh[p] += a;
			sum_b_sh[p] += b;
			for (int i = 0; i <= p; i++) sum_ab_sh[i][p] += last_a[i] * longint'(b);
		end
		if (p + 1 < d) begin
			elem_pos = p + 1;
		end else begin
			elem_pos = 0;
			if (room) n_samples++;
			if (fin) begin
				wn = n_samples;
				den = wn * wn;
				for (int i = 0; i < d; i++) begin
					for (int j = i; j < d; j++) begin
						if (den == 0) begin
							quo = 0;
						end else begin
							num = wn * 128'(signed'(sum_ab_sh[i][j]))
								- 128'(signed'(sum_a_sh[i])) * 128'(signed'(sum_b_sh[j]));
							quo = num / den;
							// truncation toward zero -> floor
							if ((num % den) != 0 && num < 0) quo = quo - 1;
						end
						e.cov = quo[COV_W-1:0];
						e.row = i[OIDX_W-1:0];
						e.col = j[OIDX_W-1:0];
						e.last = (i == d - 1) && (j == d - 1);
						cov_expect_q = {cov_expect_q, e};
					end
				end
				clear_sums();
			end
		end
	endtask

	// Driver: feeds elements and register writes from pending_q
	int drv_gap;
	int settle_cnt;
	always @(posedge clk or negedge arst_n) begin
		bit       nxt_in;
		bit       nxt_cfg;
		request_t r;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			cfg_valid    <= 1'b0;
			a_value      <= '0;
			b_value      <= '0;
			final_sample <= 1'b0;
			cfg_dim      <= ACTIVE_DIM_RST;
			drv_gap      <= 0;
			settle_cnt   <= 0;
		end else begin
			nxt_in = in_valid;
			nxt_cfg = cfg_valid;
			if (in_valid && !in_stall) begin
				accumulate_element(a_value, b_value, final_sample);
				nxt_in = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				dim_reg = cfg_dim;
				clear_sums();
				nxt_cfg = 1'b0;
			end
			if (!nxt_in && !nxt_cfg) begin
				if (drv_gap > 0) begin
					drv_gap <= drv_gap - 1;
				end else if (pending_q.size() > 0) begin
					r = pending_q[0];
					if (r.is_cfg) begin
						// write only once the block has gone quiet
						if (cov_expect_q.size() != 0) begin
							settle_cnt <= 0;
						end else if (settle_cnt < SETTLE_CYC) begin
							settle_cnt <= settle_cnt + 1;
						end else begin
							void'(pending_q.pop_front());
							cfg_dim <= r.dim;
							nxt_cfg = 1'b1;
							settle_cnt <= 0;
							drv_gap <= $urandom_range(0, 4);
						end
					end else begin
						void'(pending_q.pop_front());
						a_value <= r.a;
						b_value <= r.b;
						final_sample <= r.fin;
						nxt_in = 1'b1;
						drv_gap <= r.no_gap ? 0 : $urandom_range(0, 4);
					end
				end
			end
			in_valid <= nxt_in;
			cfg_valid <= nxt_cfg;
		end
	end

	// Monitor: random receiver stalls, one long hold-off, and result checks
	int rx_wait;
	always @(posedge clk or negedge arst_n) begin
		int         nw;
		cov_entry_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait   <= 0;
		end else begin
			nw = rx_wait;
			if (nw > 0) nw--;
			if (out_valid && !out_stall) begin
				entries_seen++;
				if (cov_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected entry cov=%0d row=%0d col=%0d last=%0b",
							cov_value, row_index, col_index, last_entry);
				end else begin
					e = cov_expect_q.pop_front();
					if (e.cov !== cov_value || e.row !== row_index ||
							e.col !== col_index || e.last !== last_entry) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch exp cov=%0d r=%0d c=%0d l=%0b, got cov=%0d r=%0d c=%0d l=%0b",
								$signed(e.cov), e.row, e.col, e.last,
								cov_value, row_index, col_index, last_entry);
					end
				end
				// early in the run, hold off long enough to back up the block
				nw = (entries_seen == 5) ? HOLD_CYC : $urandom_range(0, 4);
			end
			rx_wait <= nw;
			out_stall <= (nw > 0);
		end
	end

	// Watchdog on cycles with no accepted request
	int idle_cyc = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cyc <= 0;
		else if (idle_cyc >= WATCHDOG) begin
			$display("** cross_covariance_upper_triangle_top: FAILED **");
			$finish;
		end else
			idle_cyc <= idle_cyc + 1;
	end

	function automatic logic signed [A_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			default: return A_W'($urandom());
		endcase
	endfunction

	task automatic add_cfg(input int d);
		request_t r;
		r = '{default: 0};
		r.is_cfg = 1;
		r.dim = CFG_W'(d);
		pending_q = {pending_q, r};
	endtask

	task automatic add_elem(input logic signed [A_W-1:0] a,
			input logic signed [A_W-1:0] b, input bit fin, input bit no_gap);
		request_t r;
		r = '{default: 0};
		r.a = a;
		r.b = b;
		r.fin = fin;
		r.no_gap = no_gap;
		pending_q = {pending_q, r};
	endtask

	initial begin
		int d;
		int ns;
		int made;
		bit noise;
		dim_reg = ACTIVE_DIM_RST;
		clear_sums();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset dim of 8, extremes, stray final flags mid-sample
		for (int e = 0; e < 8; e++)
			add_elem(e[0] ? 16'sh7fff : 16'sh8000, e[1] ? 16'sh8000 : 16'sh7fff, e == 3, 0);
		for (int e = 0; e < 8; e++)
			add_elem(16'sh0000, 16'shffff, e == 7, 0);
		// next set queued right behind, offered while the receiver holds off
		for (int e = 0; e < 8; e++) add_elem(pick_value(), pick_value(), e == 7, 0);
		// one-sample set: zero covariance
		add_cfg(1);
		add_elem(16'sh7fff, 16'sh7fff, 1, 0);
		// zero acts as one
		add_cfg(0);
		add_elem(16'sh8000, 16'sh8000, 0, 0);
		add_elem(16'sh8000, 16'sh8000, 0, 0);
		add_elem(16'sh7fff, 16'sh8000, 1, 0);
		// above the cap acts as the cap
		add_cfg(15);
		for (int e = 0; e < 8; e++) add_elem(pick_value(), pick_value(), e == 7, 0);

		// Random sets: mostly well-formed, some with stray flags or cut short
		made = 0;
		while (made < 170) begin
			if ($urandom_range(0, 2) == 0) add_cfg($urandom_range(0, 15));
			d = dim_reg;
			d = $urandom_range(1, 8);
			add_cfg(d);
			ns = $urandom_range(1, 4);
			noise = ($urandom_range(0, 4) == 0);
			for (int s = 0; s < ns; s++)
				for (int e = 0; e < d; e++) begin
					add_elem(pick_value(), pick_value(),
						(e == d - 1) ? (s == ns - 1 && !(noise && s == 0 && ns == 1))
							: (noise ? 1'($urandom_range(0, 1)) : 1'b0), 0);
					made++;
				end
		end
		add_cfg(8);

		wait (pending_q.size() == 0 && !in_valid && !cfg_valid);
		wait (cov_expect_q.size() == 0);
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatches == 0 && cov_expect_q.size() == 0)
			$display("** cross_covariance_upper_triangle_top: PASSED **");
		else
			$display("** cross_covariance_upper_triangle_top: FAILED **");
		$finish;
	end
endmodule

[sim.f]
hw/rtl/ccut_pkg.sv
hw/rtl/ccut_ctrl.sv
hw/rtl/ccut_dp.sv
hw/rtl/cross_covariance_upper_triangle_top.sv
tb/testbench.sv
